FILE: src/saq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted alarm queue package
// Shared types and command codes for the sorted alarm queue unit.
// ----------------------------------------------------------------------------
package saq_pkg;

  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_SET_ABS  = 3'd1,
    CMD_SET_REL  = 3'd2,
    CMD_SET_PER  = 3'd3,
    CMD_CANCEL   = 3'd4,
    CMD_TICK     = 3'd5
  } saq_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNQ,
    ST_APPLY,
    ST_ENQ,
    ST_TICK,
    ST_DIV,
    ST_EMIT
  } saq_state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  slot;
    logic [63:0] time_value;
    logic [63:0] period_ticks;
    logic        handler_present;
  } saq_in_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  alarm_slot;
    logic        call_handler;
    logic        last;
    logic        queue_nonempty;
    logic [63:0] now_time;
  } saq_out_t;

  localparam int OUT_LIMIT = 32;

endpackage

FILE: src/sorted_alarm_queue_unit.sv
// ----------------------------------------------------------------------------
// Sorted alarm queue unit
// Alarm slots kept in a queue ordered by fire time, with periodic re-arm.
// ----------------------------------------------------------------------------
// Usage: each word on the in_ channel is one command (clear, arm absolute,
// arm relative, arm periodic, cancel, tick). The unit takes one word at a
// time; in_ready is low from acceptance until its last result word leaves.
// A non-tick command gives one result word. A tick gives one word per due
// alarm removed from the head of the queue (at most MAX_DUE, capped at 32),
// or one word with fired low when nothing is due; last marks the final one.
// Removing a slot scans the queue one entry per cycle, and inserting
// walks it with one 64-bit compare per cycle. Each periodic alarm taken
// by a tick runs the shared restoring divider and then a sorted insert;
// a one-shot alarm taken by a tick is only removed from the head.
// The result words are held on out_ until out_ready is high; a stalled
// receiver simply freezes the unit. Synchronous reset empties the queue,
// clears all handler marks and sets the tick time to zero.
// ----------------------------------------------------------------------------
module sorted_alarm_queue_unit #(
  parameter int SLOTS   = 16,
  parameter int MAX_DUE = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  saq_pkg::saq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output saq_pkg::saq_out_t out_data
);
  import saq_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW    = $clog2(SLOTS + 1);
  localparam int LIMIT = (MAX_DUE < OUT_LIMIT) ? MAX_DUE : OUT_LIMIT;
  localparam int NW    = $clog2(LIMIT + 1);
  localparam int BW    = (LIMIT > 1) ? $clog2(LIMIT) : 1;

  saq_state_t state_r, state_nxt;

  logic [63:0]   ft_r  [SLOTS];
  logic [63:0]   per_r [SLOTS];
  logic          hh_r  [SLOTS];
  logic [SW-1:0] ord_r [SLOTS];
  logic [LW-1:0] len_r;
  logic [63:0]   now_r;

  logic [2:0]    cmd_r;
  logic [SW-1:0] tgt_r;
  logic [63:0]   tv_r;
  logic [63:0]   pin_r;
  logic          hp_r;
  logic          is_tick_r;
  logic [LW-1:0] idx_r;
  logic [63:0]   key_r;

  logic [63:0]   dvd_r;
  logic [63:0]   rem_r;
  logic [63:0]   div_r;
  logic [5:0]    cnt_r;

  logic [SW-1:0] dslot_r [LIMIT];
  logic          dcall_r [LIMIT];
  logic [NW-1:0] n_r;
  logic [NW-1:0] oidx_r;

  logic [SW-1:0] rd_addr;
  logic [63:0]   ft_rd;
  logic [64:0]   rem_sh;
  logic          unq_hit;
  logic          enq_walk;
  logic          tick_due;
  logic          emit_last;
  logic          in_acc;
  logic          slot_ok;

  assign in_acc   = in_valid && in_ready;
  assign slot_ok  = 32'(in_data.slot) < SLOTS;
  assign rd_addr  = (state_r == ST_ENQ) ? ord_r[idx_r[SW-1:0]] : ord_r[0];
  assign ft_rd    = ft_r[rd_addr];
  assign rem_sh   = {rem_r, dvd_r[63]};
  assign unq_hit  = (idx_r != len_r) && (ord_r[idx_r[SW-1:0]] == tgt_r);
  assign enq_walk = (idx_r != len_r) && (ft_rd <= key_r);
  assign tick_due = (len_r != '0) && (32'(n_r) < LIMIT) && (ft_rd <= now_r);
  assign emit_last = (n_r == '0) || (oidx_r == n_r - NW'(1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == CMD_TICK) begin
            state_nxt = ST_TICK;
          end else if (slot_ok && in_data.command <= CMD_CANCEL) begin
            state_nxt = ST_UNQ;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_UNQ: begin
        if (idx_r == len_r || unq_hit) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (cmd_r == CMD_CLEAR || cmd_r == CMD_CANCEL) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_ENQ;
        end
      end
      ST_ENQ: begin
        if (32'(len_r) >= SLOTS || !enq_walk) begin
          state_nxt = is_tick_r ? ST_TICK : ST_EMIT;
        end
      end
      ST_TICK: begin
        if (!tick_due) begin
          state_nxt = ST_EMIT;
        end else if (per_r[rd_addr] != '0) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == 6'd63) begin
          state_nxt = ST_ENQ;
        end
      end
      ST_EMIT: begin
        if (out_ready && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    out_data  = '0;
    out_data.last           = emit_last;
    out_data.queue_nonempty = (len_r != '0);
    out_data.now_time       = now_r;
    if (n_r != '0) begin
      out_data.fired        = 1'b1;
      out_data.alarm_slot   = 4'(dslot_r[oidx_r[BW-1:0]]);
      out_data.call_handler = dcall_r[oidx_r[BW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      now_r   <= '0;
      for (int j = 0; j < SLOTS; j++) begin
        hh_r[j] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            cmd_r     <= in_data.command;
            tgt_r     <= SW'(in_data.slot);
            tv_r      <= in_data.time_value;
            pin_r     <= in_data.period_ticks;
            hp_r      <= in_data.handler_present;
            is_tick_r <= (in_data.command == CMD_TICK);
            idx_r     <= '0;
            n_r       <= '0;
            oidx_r    <= '0;
            if (in_data.command == CMD_TICK) begin
              now_r <= in_data.time_value;
            end
          end
        end
        ST_UNQ: begin
          if (unq_hit) begin
            for (int j = 0; j < SLOTS - 1; j++) begin
              if (j >= int'(idx_r)) begin
                ord_r[j] <= ord_r[j+1];
              end
            end
            len_r <= len_r - LW'(1);
          end else if (idx_r != len_r) begin
            idx_r <= idx_r + LW'(1);
          end
        end
        ST_APPLY: begin
          idx_r <= '0;
          case (cmd_r)
            CMD_CLEAR: begin
              hh_r[tgt_r]  <= 1'b0;
              ft_r[tgt_r]  <= '0;
              per_r[tgt_r] <= '0;
            end
            CMD_SET_ABS, CMD_SET_REL: begin
              hh_r[tgt_r]  <= hp_r;
              per_r[tgt_r] <= '0;
              ft_r[tgt_r]  <= (cmd_r == CMD_SET_ABS) ? tv_r : now_r + tv_r;
              key_r        <= (cmd_r == CMD_SET_ABS) ? tv_r : now_r + tv_r;
            end
            CMD_SET_PER: begin
              hh_r[tgt_r]  <= hp_r;
              per_r[tgt_r] <= pin_r;
              ft_r[tgt_r]  <= tv_r;
              key_r        <= tv_r;
            end
            default: begin
              hh_r[tgt_r] <= 1'b0;
            end
          endcase
        end
        ST_ENQ: begin
          if (32'(len_r) < SLOTS) begin
            if (enq_walk) begin
              idx_r <= idx_r + LW'(1);
            end else begin
              for (int j = 1; j < SLOTS; j++) begin
                if (j > int'(idx_r)) begin
                  ord_r[j] <= ord_r[j-1];
                end
              end
              ord_r[idx_r[SW-1:0]] <= tgt_r;
              len_r <= len_r + LW'(1);
            end
          end
        end
        ST_TICK: begin
          if (tick_due) begin
            for (int j = 0; j < SLOTS - 1; j++) begin
              ord_r[j] <= ord_r[j+1];
            end
            len_r <= len_r - LW'(1);
            dslot_r[n_r[BW-1:0]] <= rd_addr;
            dcall_r[n_r[BW-1:0]] <= hh_r[rd_addr];
            n_r   <= n_r + NW'(1);
            tgt_r <= rd_addr;
            dvd_r <= now_r - ft_rd;
            div_r <= per_r[rd_addr];
            rem_r <= '0;
            cnt_r <= '0;
          end
        end
        ST_DIV: begin
          dvd_r <= {dvd_r[62:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
          if (rem_sh >= {1'b0, div_r}) begin
            rem_r <= 64'(rem_sh - {1'b0, div_r});
          end else begin
            rem_r <= rem_sh[63:0];
          end
          if (cnt_r == 6'd63) begin
            idx_r <= '0;
            if (rem_sh >= {1'b0, div_r}) begin
              ft_r[tgt_r] <= now_r - 64'(rem_sh - {1'b0, div_r}) + div_r;
              key_r       <= now_r - 64'(rem_sh - {1'b0, div_r}) + div_r;
            end else begin
              ft_r[tgt_r] <= now_r - rem_sh[63:0] + div_r;
              key_r       <= now_r - rem_sh[63:0] + div_r;
            end
          end
        end
        ST_EMIT: begin
          if (out_ready && !emit_last) begin
            oidx_r <= oidx_r + NW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/saq_checker.sv
// ----------------------------------------------------------------------------
// Sorted alarm queue checker
// Port-level checks over time for the sorted alarm queue unit.
// ----------------------------------------------------------------------------
module saq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input saq_pkg::saq_out_t out_data
);
  import saq_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result word is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready again right after an accepted word");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.fired) |->
      (out_data.alarm_slot == 4'd0 && !out_data.call_handler && out_data.last))
    else $error("non-fired result word carries alarm data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result word changed");

endmodule

bind sorted_alarm_queue_unit saq_checker u_saq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
